[rtl/odc_pkg.sv]
// ----------------------------------------------------------------------------
// odc_pkg
// Shared types, constants and depths for the optical drive command controller.
// ----------------------------------------------------------------------------
package odc_pkg;

    // FIFO depths.
    localparam int PARAM_DEPTH    = 16;
    localparam int RESPONSE_DEPTH = 16;
    localparam int IRQ_DEPTH      = 16;

    localparam int P_AW     = $clog2(PARAM_DEPTH);
    localparam int P_CNT_W  = $clog2(PARAM_DEPTH + 1);
    localparam int R_AW     = $clog2(RESPONSE_DEPTH);
    localparam int R_CNT_W  = $clog2(RESPONSE_DEPTH + 1);
    localparam int I_CNT_W  = $clog2(IRQ_DEPTH + 1);

    // Field widths.
    localparam int REQ_TYPE_W = 2;
    localparam int PORT_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // Request types.
    localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_TICK  = 2'd2;

    // Host ports.
    localparam logic [PORT_W-1:0] PORT_STATUS = 2'd0;
    localparam logic [PORT_W-1:0] PORT_DATA   = 2'd1;
    localparam logic [PORT_W-1:0] PORT_CTRL   = 2'd2;
    localparam logic [PORT_W-1:0] PORT_ACK    = 2'd3;

    // Banks.
    localparam logic [1:0] BANK_0 = 2'd0;
    localparam logic [1:0] BANK_1 = 2'd1;
    localparam logic [1:0] BANK_3 = 2'd3;

    // Commands and sub-commands.
    localparam logic [BYTE_W-1:0] CMD_GET_STATUS = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_TEST       = 8'h19;
    localparam logic [BYTE_W-1:0] SUB_VERSION    = 8'h20;

    // Interrupt type queued by every answered command.
    localparam logic [2:0] IRQ_TYPE_ACK = 3'b011;
    localparam logic [2:0] IRQ_TYPE_MASK = 3'b111;

    // Fixed read values and bit positions.
    localparam logic [BYTE_W-1:0] IRQ_FLAG_BASE = 8'b1110_0000;
    localparam int ACK_CLR_PARAM_BIT = 6;

    // Version answer of the test command.
    localparam int VERSION_LEN = 4;
    localparam logic [1:0] VERSION_LAST = 2'(VERSION_LEN - 1);
    localparam logic [BYTE_W-1:0] VERSION_BYTES [VERSION_LEN] =
        '{8'h94, 8'h09, 8'h19, 8'hC0};

    // Configuration register decode: paddr[2] selects the register word.
    localparam logic CFG_DRIVE_STATUS = 1'b0;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_RSP_WAIT = 5'b00010,
        S_CMD_WAIT = 5'b00100,
        S_CMD_PUSH = 5'b01000,
        S_EMIT     = 5'b10000
    } state_t;

endpackage

[rtl/odc_ifs.sv]
// ----------------------------------------------------------------------------
// odc_ifs
// Valid/ready channels for host requests and their results.
// ----------------------------------------------------------------------------
interface odc_req_if;
    import odc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [PORT_W-1:0]     reg_addr;
    logic [BYTE_W-1:0]     write_data;

    modport source (output valid, output req_type, output reg_addr,
                    output write_data, input ready);
    modport sink   (input valid, input req_type, input reg_addr,
                    input write_data, output ready);
endinterface

interface odc_rsp_if;
    import odc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              irq_request;
    logic              access_error;

    modport source (output valid, output read_data, output irq_request,
                    output access_error, input ready);
    modport sink   (input valid, input read_data, input irq_request,
                    input access_error, output ready);
endinterface

[rtl/odc_ram.sv]
// ----------------------------------------------------------------------------
// odc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module odc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/optical_drive_command_controller.sv]
// ----------------------------------------------------------------------------
// optical_drive_command_controller
// Indexed four-port drive controller with parameter and response FIFOs.
// ----------------------------------------------------------------------------
// Usage:
// The host sends requests on req (read, write or tick, with a port number
// and a write byte) and takes one result per request on rsp (read byte,
// interrupt request, access error). The user sets the drive status byte
// via APB address 0 only while idle; the block does not enforce this.
// Parameters and responses live in two RAMs with a registered read; the
// sequencer reads, updates the FIFO pointers and writes back.
// Most requests finish in the accept cycle, their result registered in the
// output register; a response pop passes S_RSP_WAIT, the test command with
// version answer S_CMD_WAIT (one parameter read), then S_CMD_PUSH (four
// response writes on the single RAM write port). Requests are taken in idle
// only, so simple requests run at one per cycle while results are taken.
// A result waits in an output register; a further simple request may be
// taken while it waits, and its result then holds in a pending register
// until the receiver takes the first one.
// Reset empties all FIFOs, clears bank, enable and status registers.
// ----------------------------------------------------------------------------
module optical_drive_command_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    odc_req_if.sink                req,
    odc_rsp_if.source              rsp,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [odc_pkg::PADDR_W-1:0] paddr,
    input  logic [odc_pkg::PDATA_W-1:0] pwdata,
    output logic [odc_pkg::PDATA_W-1:0] prdata,
    output logic                   pready
);
    import odc_pkg::*;

    state_t state_reg, state_next;

    logic [1:0]        bank_reg, bank_next;
    logic [BYTE_W-1:0] int_en_reg, int_en_next;
    logic [BYTE_W-1:0] dsb_reg;

    logic [P_AW-1:0]    p_head_reg, p_head_next;
    logic [P_AW-1:0]    p_tail_reg, p_tail_next;
    logic [P_CNT_W-1:0] p_cnt_reg, p_cnt_next;
    logic [R_AW-1:0]    r_head_reg, r_head_next;
    logic [R_CNT_W-1:0] r_cnt_reg, r_cnt_next;
    logic [I_CNT_W-1:0] irq_cnt_reg, irq_cnt_next;
    logic [1:0]         push_idx_reg, push_idx_next;

    logic [BYTE_W-1:0] pend_rd_reg, pend_rd_next;
    logic              pend_irq_reg, pend_irq_next;
    logic              pend_err_reg, pend_err_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_rd_reg, out_rd_next;
    logic              out_irq_reg, out_irq_next;
    logic              out_err_reg, out_err_next;

    logic              p_we, r_we;
    logic [BYTE_W-1:0] p_rdata, r_rdata, r_wdata;
    logic [R_AW-1:0]   r_waddr;

    logic              fin;
    logic [BYTE_W-1:0] fin_rd;
    logic              fin_irq, fin_err;
    logic              slot_free, accept;
    logic [BYTE_W-1:0] status;
    logic              cfg_write;

    // Parameter and response storage.
    odc_ram #(.WIDTH(BYTE_W), .DEPTH(PARAM_DEPTH)) u_param_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_tail_reg),
        .wdata (req.write_data),
        .raddr (p_head_reg),
        .rdata (p_rdata)
    );

    odc_ram #(.WIDTH(BYTE_W), .DEPTH(RESPONSE_DEPTH)) u_resp_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_head_reg),
        .rdata (r_rdata)
    );

    // APB configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == CFG_DRIVE_STATUS) ?
                       {{(PDATA_W-BYTE_W){1'b0}}, dsb_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dsb_reg <= '0;
        end
        else if (cfg_write && paddr[2] == CFG_DRIVE_STATUS)
        begin
            dsb_reg <= pwdata[BYTE_W-1:0];
        end
    end

    // Handshake.
    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign slot_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = out_rd_reg;
    assign rsp.irq_request  = out_irq_reg;
    assign rsp.access_error = out_err_reg;

    // Status byte of port 0.
    always_comb
    begin
        status      = '0;
        status[1:0] = bank_reg;
        status[3]   = (p_cnt_reg == '0);
        status[4]   = (p_cnt_reg < P_CNT_W'(PARAM_DEPTH));
        status[5]   = (r_cnt_reg != '0);
    end

    // Request sequencer: decode, FIFO pointer updates and RAM accesses.
    always_comb
    begin
        state_next    = state_reg;
        bank_next     = bank_reg;
        int_en_next   = int_en_reg;
        p_head_next   = p_head_reg;
        p_tail_next   = p_tail_reg;
        p_cnt_next    = p_cnt_reg;
        r_head_next   = r_head_reg;
        r_cnt_next    = r_cnt_reg;
        irq_cnt_next  = irq_cnt_reg;
        push_idx_next = push_idx_reg;
        pend_rd_next  = pend_rd_reg;
        pend_irq_next = pend_irq_reg;
        pend_err_next = pend_err_reg;
        p_we          = 1'b0;
        r_we          = 1'b0;
        r_waddr       = '0;
        r_wdata       = dsb_reg;
        fin           = 1'b0;
        fin_rd        = '0;
        fin_irq       = 1'b0;
        fin_err       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fin = 1'b1;
                    priority if (req.req_type == REQ_READ)
                    begin
                        priority if (req.reg_addr == PORT_STATUS)
                        begin
                            fin_rd = status;
                        end
                        else if (req.reg_addr == PORT_DATA)
                        begin
                            // Pop a response byte; its data arrives next cycle.
                            if (r_cnt_reg != '0)
                            begin
                                fin        = 1'b0;
                                r_cnt_next = r_cnt_reg - R_CNT_W'(1);
                                r_head_next = (r_head_reg == R_AW'(RESPONSE_DEPTH - 1)) ?
                                              '0 : r_head_reg + R_AW'(1);
                                state_next = S_RSP_WAIT;
                            end
                        end
                        else if (req.reg_addr == PORT_ACK &&
                                 (bank_reg == BANK_1 || bank_reg == BANK_3))
                        begin
                            fin_rd = IRQ_FLAG_BASE;
                            if (irq_cnt_reg != '0)
                            begin
                                fin_rd[2:0] = IRQ_TYPE_ACK;
                            end
                        end
                        else
                        begin
                            fin_err = 1'b1;
                        end
                    end
                    else if (req.req_type == REQ_WRITE)
                    begin
                        priority if (req.reg_addr == PORT_STATUS)
                        begin
                            bank_next = req.write_data[1:0];
                        end
                        else if (req.reg_addr == PORT_DATA && bank_reg == BANK_0)
                        begin
                            // Command: drop old answers and pending interrupts.
                            irq_cnt_next = '0;
                            r_cnt_next   = '0;
                            r_head_next  = '0;
                            priority if (req.write_data == CMD_GET_STATUS)
                            begin
                                r_we         = 1'b1;
                                r_waddr      = '0;
                                r_wdata      = dsb_reg;
                                r_cnt_next   = R_CNT_W'(1);
                                irq_cnt_next = I_CNT_W'(1);
                            end
                            else if (req.write_data == CMD_TEST && p_cnt_reg != '0)
                            begin
                                // Pop the sub-command from the parameter FIFO.
                                fin         = 1'b0;
                                p_cnt_next  = p_cnt_reg - P_CNT_W'(1);
                                p_head_next = (p_head_reg == P_AW'(PARAM_DEPTH - 1)) ?
                                              '0 : p_head_reg + P_AW'(1);
                                state_next  = S_CMD_WAIT;
                            end
                            else
                            begin
                                fin_err = 1'b1;
                            end
                        end
                        else if ((req.reg_addr == PORT_DATA) ||
                                 (req.reg_addr == PORT_CTRL && bank_reg == BANK_0))
                        begin
                            // Parameter push; dropped when the FIFO is full.
                            if (p_cnt_reg < P_CNT_W'(PARAM_DEPTH))
                            begin
                                p_we        = 1'b1;
                                p_cnt_next  = p_cnt_reg + P_CNT_W'(1);
                                p_tail_next = (p_tail_reg == P_AW'(PARAM_DEPTH - 1)) ?
                                              '0 : p_tail_reg + P_AW'(1);
                            end
                        end
                        else if (req.reg_addr == PORT_CTRL && bank_reg == BANK_1)
                        begin
                            int_en_next = req.write_data;
                        end
                        else if (req.reg_addr == PORT_ACK && bank_reg == BANK_1)
                        begin
                            // Acknowledge: optional parameter clear, pop one type.
                            if (req.write_data[ACK_CLR_PARAM_BIT])
                            begin
                                p_cnt_next  = '0;
                                p_tail_next = p_head_reg;
                            end
                            if (irq_cnt_reg != '0)
                            begin
                                irq_cnt_next = irq_cnt_reg - I_CNT_W'(1);
                            end
                        end
                        else
                        begin
                            fin_err = 1'b1;
                        end
                    end
                    else if (req.req_type == REQ_TICK)
                    begin
                        fin_irq = (irq_cnt_reg != '0) &&
                                  ((IRQ_TYPE_ACK & int_en_reg[2:0] & IRQ_TYPE_MASK) != '0);
                    end
                    else
                    begin
                        fin_err = 1'b1;
                    end
                end
            end

            S_RSP_WAIT:
            begin
                fin    = 1'b1;
                fin_rd = r_rdata;
            end

            S_CMD_WAIT:
            begin
                // Sub-command byte is now on the parameter RAM output.
                if (p_rdata == SUB_VERSION)
                begin
                    irq_cnt_next  = I_CNT_W'(1);
                    push_idx_next = '0;
                    state_next    = S_CMD_PUSH;
                end
                else
                begin
                    fin     = 1'b1;
                    fin_err = 1'b1;
                end
            end

            S_CMD_PUSH:
            begin
                // One version byte per cycle into the response RAM.
                r_we          = 1'b1;
                r_waddr       = R_AW'(push_idx_reg);
                r_wdata       = VERSION_BYTES[push_idx_reg];
                r_cnt_next    = R_CNT_W'(push_idx_reg) + R_CNT_W'(1);
                push_idx_next = push_idx_reg + 2'd1;
                if (push_idx_reg == VERSION_LAST)
                begin
                    fin = 1'b1;
                end
            end

            S_EMIT:
            begin
                fin     = 1'b1;
                fin_rd  = pend_rd_reg;
                fin_irq = pend_irq_reg;
                fin_err = pend_err_reg;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Hand a finished result to the output register or park it.
        if (fin)
        begin
            if (slot_free)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                pend_rd_next  = fin_rd;
                pend_irq_next = fin_irq;
                pend_err_next = fin_err;
                state_next    = S_EMIT;
            end
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_rd_next    = out_rd_reg;
        out_irq_next   = out_irq_reg;
        out_err_next   = out_err_reg;
        if (slot_free)
        begin
            out_valid_next = fin;
            out_rd_next    = fin_rd;
            out_irq_next   = fin_irq;
            out_err_next   = fin_err;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bank_reg      <= '0;
            int_en_reg    <= '0;
            p_head_reg    <= '0;
            p_tail_reg    <= '0;
            p_cnt_reg     <= '0;
            r_head_reg    <= '0;
            r_cnt_reg     <= '0;
            irq_cnt_reg   <= '0;
            push_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            int_en_reg    <= int_en_next;
            p_head_reg    <= p_head_next;
            p_tail_reg    <= p_tail_next;
            p_cnt_reg     <= p_cnt_next;
            r_head_reg    <= r_head_next;
            r_cnt_reg     <= r_cnt_next;
            irq_cnt_reg   <= irq_cnt_next;
            push_idx_reg  <= push_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        pend_rd_reg  <= pend_rd_next;
        pend_irq_reg <= pend_irq_next;
        pend_err_reg <= pend_err_next;
        out_rd_reg   <= out_rd_next;
        out_irq_reg  <= out_irq_next;
        out_err_reg  <= out_err_next;
    end

    // The parameter FIFO never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        p_cnt_reg <= P_CNT_W'(PARAM_DEPTH))
        else $error("parameter count above depth");

    // Responses only come from one command answer, so at most four bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        r_cnt_reg <= R_CNT_W'(VERSION_LEN))
        else $error("response count above answer length");

    // Commands clear the interrupt queue before queuing one type.
    assert property (@(posedge clk) disable iff (!rst_n)
        irq_cnt_reg <= I_CNT_W'(1))
        else $error("more than one pending interrupt");

    // While the version answer is written, the count tracks the write index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMD_PUSH) |-> (r_cnt_reg == R_CNT_W'(push_idx_reg)))
        else $error("response count out of step with version push");

endmodule
